@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/lpfd_pkg.sv @@
// Types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int MAX_WORDS = 32;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int WCNT_W    = $clog2(MAX_WORDS + 1);
  localparam int BCNT_W    = WCNT_W + 1;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd170;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd85;

  // Configuration register indexes.
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_ENDB,
    ST_RD,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load_len;
    logic take_data;
    logic clear;
    logic rd_en;
    logic emit_next;
  } dp_cmd_t;

  typedef struct packed {
    logic start_match;
    logic end_match;
    logic len_bad;
    logic len_zero;
    logic wc_zero;
    logic data_done;
    logic emit_last;
  } dp_status_t;

endpackage

@@ src/lpfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lpfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lpfd_ctrl.sv @@
// Frame parse and word emit state machine.
module lpfd_ctrl import lpfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_HUNT: begin
        if (in_acc && status.start_match && !in_last) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (in_acc) begin
          if (in_last || status.len_bad) state_next = ST_HUNT;
          else if (status.len_zero)      state_next = ST_ENDB;
          else                           state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          if (in_last)               state_next = ST_HUNT;
          else if (status.data_done) state_next = ST_ENDB;
        end
      end
      ST_ENDB: begin
        if (in_acc) begin
          if (status.end_match && !status.wc_zero) state_next = ST_RD;
          else                                     state_next = ST_HUNT;
        end
      end
      ST_RD: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_acc) state_next = status.emit_last ? ST_HUNT : ST_RD;
      end
      default: state_next = ST_HUNT;
    endcase
  end

  // Ready is constant within each state, so the handshake is the valid input.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_HUNT: begin
        in_ready = 1'b1;
      end
      ST_LEN: begin
        in_ready     = 1'b1;
        cmd.load_len = in_valid && !in_last && !status.len_bad;
        cmd.clear    = in_valid && (in_last || status.len_bad);
      end
      ST_DATA: begin
        in_ready      = 1'b1;
        cmd.take_data = in_valid && !in_last;
        cmd.clear     = in_valid && in_last;
      end
      ST_ENDB: begin
        in_ready  = 1'b1;
        cmd.clear = in_valid && !(status.end_match && !status.wc_zero);
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_SEND: begin
        out_valid     = 1'b1;
        cmd.emit_next = out_ready && !status.emit_last;
        cmd.clear     = out_ready && status.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/lpfd_dpath.sv @@
// Byte compare, word assembly, word store and emit counter.
module lpfd_dpath import lpfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0] data_byte,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic [WORD_W-1:0] sample_word,
  output logic              frame_last
);

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic [WCNT_W-1:0] word_count;
  logic [BCNT_W-1:0] bytes_received;
  logic [BYTE_W-1:0] high_byte_hold;
  logic [WCNT_W-1:0] emit_idx;
  logic [BCNT_W-1:0] bytes_plus1;
  logic [WCNT_W-1:0] emit_plus1;
  logic              ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      end_byte   <= END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default:        start_byte <= start_byte;
      endcase
    end
  end

  assign bytes_plus1 = bytes_received + BCNT_W'(1);
  assign emit_plus1  = emit_idx + WCNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      word_count     <= '0;
      bytes_received <= '0;
      high_byte_hold <= '0;
      emit_idx       <= '0;
    end else begin
      if (cmd.load_len) begin
        word_count     <= data_byte[WCNT_W-1:0];
        bytes_received <= '0;
      end
      if (cmd.take_data) begin
        if (!bytes_received[0]) high_byte_hold <= data_byte;
        bytes_received <= bytes_plus1;
      end
      if (cmd.emit_next) emit_idx <= emit_plus1;
    end
  end

  assign status.start_match = (data_byte == start_byte);
  assign status.end_match   = (data_byte == end_byte);
  assign status.len_bad     = (data_byte > BYTE_W'(MAX_WORDS));
  assign status.len_zero    = (data_byte == '0);
  assign status.wc_zero     = (word_count == '0);
  assign status.data_done   = (bytes_plus1 >= {word_count, 1'b0});
  assign status.emit_last   = (emit_plus1 == word_count);

  // Second byte of a pair completes a word.
  assign ram_we = cmd.take_data && bytes_received[0];

  lpfd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bytes_received[ADDR_W:1]),
    .wdata ({high_byte_hold, data_byte}),
    .re    (cmd.rd_en),
    .raddr (emit_idx[ADDR_W-1:0]),
    .rdata (sample_word)
  );

  assign frame_last = status.emit_last;

endmodule

@@ src/length_prefixed_frame_deframer_top.sv @@
// Top level of the length-prefixed frame deframer.
//
// Input stream: one received byte per word on s_axis_tdata; s_axis_tlast
// marks the last byte of a read, and a frame not finished by it is dropped.
// A frame is start byte, length byte (count of 16-bit words, at most 32),
// the words high byte first, then the end byte. Only a frame whose end byte
// matches is sent on the output stream, one 16-bit word per transfer, with
// m_axis_tlast on its final word. Bad frames produce nothing.
// Input bytes are taken at one per cycle while parsing. After a good end
// byte the block stops taking input and sends its words, each with a
// store read and then an output step, since the store read is
// registered; the input stays held until the final word is taken,
// output stalls included. After the end byte is accepted, the controller
// passes through the store read state before m_axis_tvalid rises.
// A stalled receiver simply holds the current word on the output.
// Start and end byte values are written on the cfg port (index 0 start,
// 1 end). Reset (synchronous) returns to hunting with 0xAA and 0x55.
module length_prefixed_frame_deframer_top import lpfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // buffer_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata,   // [15:0] sample_word
  output logic              m_axis_tlast    // frame_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lpfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lpfd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_byte   (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .sample_word (m_axis_tdata),
    .frame_last  (m_axis_tlast)
  );

endmodule

@@ src/lpfd_checker.sv @@
// Port-level checks of the deframer, bound to its top level.
`include "assert_macros.svh"

module lpfd_checker import lpfd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [WORD_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

  `ASSERT_ALWAYS(a_rst_idle, rst |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

  `ASSERT_CLK(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "input taken during emit")

  `ASSERT_CLK(a_word_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid ##1 m_axis_tvalid, "next word of frame not sent")

  `ASSERT_CLK(a_resume, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid, "input not resumed after frame")

endmodule

bind length_prefixed_frame_deframer_top lpfd_checker u_lpfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
